// File: design/ferp_pkg.sv
// Shared types, codes and the microprogram for the flash erase range planner.
// No dependencies; used by ferp_useq, ferp_dpath and the top level.
package ferp_pkg;

  localparam int ADDR_W      = 24;
  localparam int COUNT_W     = 21;
  localparam int LEN_W       = 17;
  localparam int REM_W       = 25;
  localparam int MAX_RESULTS = 48;
  localparam int CNT_W       = 6;
  localparam int STEP_W      = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  localparam logic [1:0] KIND_BLOCK   = 2'd0;
  localparam logic [1:0] KIND_SECTOR  = 2'd1;
  localparam logic [1:0] KIND_PARTIAL = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_LOAD = 2'd1,
    OP_EMIT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    WT_NONE     = 2'd0,
    WT_IN_VALID = 2'd1,
    WT_OUT_FREE = 2'd2
  } wait_t;

  typedef enum logic [1:0] {
    BR_NEVER    = 2'd0,
    BR_ALWAYS   = 2'd1,
    BR_REM_ZERO = 2'd2,
    BR_MORE     = 2'd3
  } br_t;

  typedef struct packed {
    op_t   op;
    wait_t wt;
    br_t   br;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic rem_zero;
    logic emit_last;
  } stat_t;

  localparam step_t ST_IDLE  = 2'd0;
  localparam step_t ST_CHECK = 2'd1;
  localparam step_t ST_EMIT  = 2'd2;
  localparam step_t ST_DONE  = 2'd3;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      ST_IDLE:  w = '{op: OP_LOAD, wt: WT_IN_VALID, br: BR_NEVER,    target: ST_IDLE};
      ST_CHECK: w = '{op: OP_NOP,  wt: WT_NONE,     br: BR_REM_ZERO, target: ST_IDLE};
      ST_EMIT:  w = '{op: OP_EMIT, wt: WT_OUT_FREE, br: BR_MORE,     target: ST_EMIT};
      ST_DONE:  w = '{op: OP_NOP,  wt: WT_NONE,     br: BR_ALWAYS,   target: ST_IDLE};
      default:  w = '{op: OP_NOP,  wt: WT_NONE,     br: BR_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: design/ferp_useq.sv
// Microcode sequencer: step counter, control-word lookup, wait and branch logic.
// Depends on ferp_pkg for the control word format and the microprogram.
module ferp_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  ferp_pkg::stat_t  stat,
  output logic             in_tready,
  output ferp_pkg::ctrl_t  ctrl
);

  ferp_pkg::step_t  step_r;
  ferp_pkg::step_t  step_nxt;
  ferp_pkg::uword_t word;
  logic             go;
  logic             taken;

  assign word = ferp_pkg::ucode(step_r);

  always_comb begin
    case (word.wt)
      ferp_pkg::WT_NONE:     go = 1'b1;
      ferp_pkg::WT_IN_VALID: go = in_tvalid;
      ferp_pkg::WT_OUT_FREE: go = stat.out_free;
      default:               go = 1'b1;
    endcase
  end

  always_comb begin
    case (word.br)
      ferp_pkg::BR_NEVER:    taken = 1'b0;
      ferp_pkg::BR_ALWAYS:   taken = 1'b1;
      ferp_pkg::BR_REM_ZERO: taken = stat.rem_zero;
      ferp_pkg::BR_MORE:     taken = !stat.emit_last;
      default:               taken = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (go) begin
      step_nxt = taken ? word.target : step_r + ferp_pkg::step_t'(1);
    end
  end

  assign in_tready = (word.op == ferp_pkg::OP_LOAD);
  assign ctrl.load = (word.op == ferp_pkg::OP_LOAD) && go;
  assign ctrl.emit = (word.op == ferp_pkg::OP_EMIT) && go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ferp_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: design/ferp_dpath.sv
// Datapath: address, remaining count and command counter, command selection
// and the output register. Depends on ferp_pkg; driven by ferp_useq.
module ferp_dpath #(
  parameter int SECTOR_BYTES    = 4096,
  parameter int BLOCK_BYTES     = 65536,
  parameter int MAX_RANGE_BYTES = 1048576
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ferp_pkg::ctrl_t                    ctrl,
  input  logic [ferp_pkg::ADDR_W-1:0]        start_address,
  input  logic [ferp_pkg::COUNT_W-1:0]       byte_count,
  input  logic                               out_tready,
  output ferp_pkg::stat_t                    stat,
  output logic                               out_valid,
  output logic [1:0]                         command_kind,
  output logic [ferp_pkg::ADDR_W-1:0]        command_address,
  output logic [ferp_pkg::LEN_W-1:0]         command_length,
  output logic                               last_command
);

  localparam logic [ferp_pkg::ADDR_W-1:0] SMASK  = ferp_pkg::ADDR_W'(SECTOR_BYTES - 1);
  localparam logic [ferp_pkg::ADDR_W-1:0] BMASK  = ferp_pkg::ADDR_W'(BLOCK_BYTES - 1);
  localparam logic [ferp_pkg::ADDR_W-1:0] SSTEP  = ferp_pkg::ADDR_W'(SECTOR_BYTES);
  localparam logic [ferp_pkg::ADDR_W-1:0] BSTEP  = ferp_pkg::ADDR_W'(BLOCK_BYTES);
  localparam logic [ferp_pkg::REM_W-1:0]  SLEN   = ferp_pkg::REM_W'(SECTOR_BYTES);
  localparam logic [ferp_pkg::REM_W-1:0]  BLEN   = ferp_pkg::REM_W'(BLOCK_BYTES);
  localparam logic [ferp_pkg::REM_W-1:0]  RLIMIT = ferp_pkg::REM_W'(MAX_RANGE_BYTES);
  localparam logic [ferp_pkg::CNT_W-1:0]  CLAST  = ferp_pkg::CNT_W'(ferp_pkg::MAX_RESULTS - 1);

  logic [ferp_pkg::ADDR_W-1:0] addr_r;
  logic [ferp_pkg::REM_W-1:0]  rem_r;
  logic [ferp_pkg::CNT_W-1:0]  cnt_r;
  logic                        out_valid_r;
  logic [1:0]                  kind_r;
  logic [ferp_pkg::ADDR_W-1:0] caddr_r;
  logic [ferp_pkg::LEN_W-1:0]  clen_r;
  logic                        last_r;

  logic [ferp_pkg::REM_W-1:0]  count_ext;
  logic [ferp_pkg::REM_W-1:0]  plen;
  logic [1:0]                  kind_sel;
  logic [ferp_pkg::REM_W-1:0]  len_sel;
  logic [ferp_pkg::ADDR_W-1:0] addr_adv;
  logic                        last_sel;

  assign count_ext = ferp_pkg::REM_W'(byte_count);

  always_comb begin
    plen = SLEN - ferp_pkg::REM_W'(addr_r & SMASK);
    if (plen > rem_r) begin
      plen = rem_r;
    end
    if (((addr_r & BMASK) == '0) && (rem_r >= BLEN)) begin
      kind_sel = ferp_pkg::KIND_BLOCK;
      len_sel  = BLEN;
      addr_adv = addr_r + BSTEP;
    end else if (((addr_r & SMASK) == '0) && (rem_r >= SLEN)) begin
      kind_sel = ferp_pkg::KIND_SECTOR;
      len_sel  = SLEN;
      addr_adv = addr_r + SSTEP;
    end else begin
      kind_sel = ferp_pkg::KIND_PARTIAL;
      len_sel  = plen;
      addr_adv = (addr_r & ~SMASK) + SSTEP;
    end
    last_sel = (rem_r == len_sel) || (cnt_r == CLAST);
  end

  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.rem_zero  = (rem_r == '0);
  assign stat.emit_last = last_sel;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      addr_r <= start_address;
      rem_r  <= (count_ext > RLIMIT) ? RLIMIT : count_ext;
    end else if (ctrl.emit) begin
      addr_r <= addr_adv;
      rem_r  <= rem_r - len_sel;
    end
    if (ctrl.emit) begin
      kind_r  <= kind_sel;
      caddr_r <= addr_r;
      clen_r  <= len_sel[ferp_pkg::LEN_W-1:0];
      last_r  <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        cnt_r <= '0;
      end else if (ctrl.emit) begin
        cnt_r <= cnt_r + ferp_pkg::CNT_W'(1);
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign command_kind    = kind_r;
  assign command_address = caddr_r;
  assign command_length  = clen_r;
  assign last_command    = last_r;

endmodule

// File: design/flash_erase_range_planner_core.sv
// Flash erase range planner top level: stream ports around the microcode
// sequencer (ferp_useq) and the datapath (ferp_dpath). Depends on ferp_pkg.
//
// Splits one erase request (24-bit start address, byte count) into block
// erase, sector erase and partial sector clear commands in address order;
// the final command carries tlast. A request is accepted in the idle step,
// checked for a zero count in the check step, issues its commands in the emit
// step and ends in the closing step of the microprogram; a zero count returns
// to idle from the check step. A command waits while the output register is
// still full. Counts above MAX_RANGE_BYTES are clamped to it, addresses wrap
// at 2^24, and at most 48 commands are issued per request.
module flash_erase_range_planner_core #(
  parameter int SECTOR_BYTES    = 4096,
  parameter int BLOCK_BYTES     = 65536,
  parameter int MAX_RANGE_BYTES = 1048576
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [23:0] start_address, [44:24] byte_count, [47:45] zero
  input  logic [ferp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [23:0] command_address, [40:24] command_length, [47:41] zero
  output logic [ferp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [1:0] command_kind
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  localparam int PAD_W = ferp_pkg::OUT_DATA_W - ferp_pkg::ADDR_W - ferp_pkg::LEN_W;

  ferp_pkg::ctrl_t             ctrl;
  ferp_pkg::stat_t             stat;
  logic [ferp_pkg::ADDR_W-1:0] command_address;
  logic [ferp_pkg::LEN_W-1:0]  command_length;

  ferp_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  ferp_dpath #(
    .SECTOR_BYTES    (SECTOR_BYTES),
    .BLOCK_BYTES     (BLOCK_BYTES),
    .MAX_RANGE_BYTES (MAX_RANGE_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .start_address   (in_tdata[ferp_pkg::ADDR_W-1:0]),
    .byte_count      (in_tdata[ferp_pkg::ADDR_W +: ferp_pkg::COUNT_W]),
    .out_tready      (out_tready),
    .stat            (stat),
    .out_valid       (out_tvalid),
    .command_kind    (out_tuser),
    .command_address (command_address),
    .command_length  (command_length),
    .last_command    (out_tlast)
  );

  assign out_tdata = {{PAD_W{1'b0}}, command_length, command_address};

endmodule

// File: sim/erase_cmd_checker.sv
// Checker for the flash erase range planner: watches both stream channels, plans the
// expected erase commands for every accepted request and compares each command transfer.
// Depends on ferp_pkg for widths and command kinds.
module erase_cmd_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ferp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ferp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                      out_tuser,
  input  logic                            out_tlast,
  output int                              mismatches,
  output int                              outstanding,
  output int                              commands_checked
);

  localparam int ADDR_W = ferp_pkg::ADDR_W;
  localparam int COUNT_W = ferp_pkg::COUNT_W;
  localparam int LEN_W = ferp_pkg::LEN_W;
  localparam int REM_W = ferp_pkg::REM_W;
  localparam int SECTOR = 4096;
  localparam int BLOCK = 65536;
  localparam int RANGE_MAX = 1048576;
  localparam logic [ADDR_W-1:0] SMASK = ADDR_W'(SECTOR - 1);
  localparam logic [ADDR_W-1:0] BMASK = ADDR_W'(BLOCK - 1);

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              last;
  } erase_cmd_t;

  erase_cmd_t planned_cmds[$];

  function automatic void plan_erase(input logic [ADDR_W-1:0] start,
                                     input logic [COUNT_W-1:0] count);
    logic [ADDR_W-1:0] addr;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  len;
    erase_cmd_t        cmd;
    int                n;
    addr = start;
    rem = REM_W'(count);
    n = 0;
    if (rem > REM_W'(RANGE_MAX)) rem = REM_W'(RANGE_MAX);
    while (rem != 0 && n < ferp_pkg::MAX_RESULTS) begin
      cmd.addr = addr;
      if ((addr & BMASK) == 0 && rem >= REM_W'(BLOCK)) begin
        cmd.kind = ferp_pkg::KIND_BLOCK;
        len = REM_W'(BLOCK);
        addr = addr + ADDR_W'(BLOCK);
      end else if ((addr & SMASK) == 0 && rem >= REM_W'(SECTOR)) begin
        cmd.kind = ferp_pkg::KIND_SECTOR;
        len = REM_W'(SECTOR);
        addr = addr + ADDR_W'(SECTOR);
      end else begin
        cmd.kind = ferp_pkg::KIND_PARTIAL;
        len = REM_W'(SECTOR) - REM_W'(addr & SMASK);
        if (len > rem) len = rem;
        addr = (addr & ~SMASK) + ADDR_W'(SECTOR);
      end
      rem = rem - len;
      n++;
      cmd.len = len[LEN_W-1:0];
      cmd.last = (rem == 0) || (n == ferp_pkg::MAX_RESULTS);
      planned_cmds.push_back(cmd);
    end
  endfunction

  task automatic report(input string what, input logic [ADDR_W-1:0] want,
                        input logic [ADDR_W-1:0] got);
    $display("ERROR command %0d: %s expected 0x%0h got 0x%0h",
             commands_checked, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    erase_cmd_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        plan_erase(in_tdata[ADDR_W-1:0], in_tdata[ADDR_W+COUNT_W-1:ADDR_W]);
      if (out_tvalid && out_tready) begin
        if (planned_cmds.size() == 0) begin
          report("unplanned command, address", '0, out_tdata[ADDR_W-1:0]);
        end else begin
          want = planned_cmds.pop_front();
          if (out_tuser != want.kind)
            report("kind", ADDR_W'(want.kind), ADDR_W'(out_tuser));
          if (out_tdata[ADDR_W-1:0] != want.addr)
            report("address", want.addr, out_tdata[ADDR_W-1:0]);
          if (out_tdata[ADDR_W+LEN_W-1:ADDR_W] != want.len)
            report("length", ADDR_W'(want.len), ADDR_W'(out_tdata[ADDR_W+LEN_W-1:ADDR_W]));
          if (out_tlast != want.last)
            report("last flag", ADDR_W'(want.last), ADDR_W'(out_tlast));
          commands_checked++;
        end
      end
    end
    outstanding <= planned_cmds.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the flash erase range planner testbench: clock, reset, request stimulus,
// random stalls on the command channel and the final verdict.
// Depends on ferp_pkg, flash_erase_range_planner_core and erase_cmd_checker.
module testbench;

  localparam int ADDR_W = ferp_pkg::ADDR_W;
  localparam int COUNT_W = ferp_pkg::COUNT_W;
  localparam int IN_DATA_W = ferp_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = ferp_pkg::OUT_DATA_W;
  localparam int RANDOM_ITEMS = 392;
  localparam int CALM_FROM = 330;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  int mismatches;
  int outstanding;
  int commands_checked;
  int requests_sent = 0;
  int directed_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  flash_erase_range_planner_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  erase_cmd_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .commands_checked (commands_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("flash_erase_range_planner_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] count);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W - ADDR_W - COUNT_W){1'b0}}, count, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_random_request;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    addr = ADDR_W'($urandom);
    case ($urandom_range(0, 3))
      0: addr[15:0] = '0;
      1: addr[11:0] = '0;
      2: addr[11:0] = 12'(12'hFFF - $urandom_range(0, 15));
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) addr[23:16] = 8'hFF;
    case ($urandom_range(0, 9))
      0, 1, 2: count = COUNT_W'($urandom_range(1, 8192));
      3, 4:    count = COUNT_W'($urandom_range(1, 140000));
      5:       count = COUNT_W'(4096 * $urandom_range(1, 20));
      6:       count = COUNT_W'(65536 * $urandom_range(1, 16));
      7:       count = COUNT_W'($urandom_range(1, 1048576));
      8:       count = COUNT_W'($urandom_range(1048577, 2097151));
      default: count = COUNT_W'($urandom_range(0, 3));
    endcase
    send_request(addr, count);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(24'h000000, 21'd1);
    send_request(24'h000000, 21'd0);
    send_request(24'hFFFFFF, 21'd1);
    send_request(24'hFFFFFF, 21'd2);
    send_request(24'hFFF000, 21'h100000);
    send_request(24'hFF0000, 21'h1FFFFF);
    send_request(24'h000000, 21'd65536);
    send_request(24'h000000, 21'd65535);
    send_request(24'h010000, 21'd65537);
    send_request(24'h001000, 21'd4096);
    send_request(24'h001000, 21'd4095);
    send_request(24'h000123, 21'd5000);
    send_request(24'h000ABC, 21'h000544);
    send_request(24'h000800, 21'h100000);
    send_request(24'h555555, 21'h0AAAAA);
    send_request(24'hAAAAAA, 21'h155555);
    send_request(24'h00FFFF, 21'd3);
    send_request(24'h00F000, 21'h011000);
    send_request(24'hFFFFFF, 21'h100000);
    directed_sent = requests_sent;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      send_random_request();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d erase requests (%0d directed, rest random) and %0d commands",
             requests_sent, directed_sent, commands_checked);
    $display("requests spanned zero and clamped counts, wrap at the top of memory, stalls");
    if (mismatches == 0) begin
      $display("flash_erase_range_planner_core: match");
    end else begin
      $display("flash_erase_range_planner_core: mismatch");
    end
    $finish;
  end

endmodule
